@@ hdl/sopep_pkg.sv @@
// Package for the sum-of-products equation parser: transfer payload types,
// parse state type, token, error and phase codes, character constants.
// No dependencies.
package sopep_pkg;

   localparam int unsigned VAR_COUNT = 26;

   // Parse phases
   localparam logic [2:0] PH_BIND      = 3'd0;
   localparam logic [2:0] PH_EQ        = 3'd1;
   localparam logic [2:0] PH_VAR       = 3'd2;
   localparam logic [2:0] PH_AFTER_VAR = 3'd3;
   localparam logic [2:0] PH_AFTER_GAP = 3'd4;

   // Token kinds
   localparam logic [2:0] TK_NONE = 3'd0;
   localparam logic [2:0] TK_VAR  = 3'd1;
   localparam logic [2:0] TK_INV  = 3'd2;
   localparam logic [2:0] TK_TERM = 3'd3;
   localparam logic [2:0] TK_END  = 3'd4;
   localparam logic [2:0] TK_ERR  = 3'd5;

   // Error codes
   localparam logic [2:0] ER_BIND  = 3'd0;
   localparam logic [2:0] ER_EQ    = 3'd1;
   localparam logic [2:0] ER_VAR   = 3'd2;
   localparam logic [2:0] ER_EARLY = 3'd3;
   localparam logic [2:0] ER_BAD   = 3'd4;

   // Characters
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [2:0]           token_kind;
      logic [4:0]           variable_index;
      logic [4:0]           binding_index;
      logic [VAR_COUNT-1:0] variables_used;
      logic [2:0]           error_code;
   } rsp_type;

   typedef struct packed {
      logic [2:0]           phase;
      logic [4:0]           binding;
      logic [VAR_COUNT-1:0] mask;
   } scan_state_type;

endpackage

@@ hdl/sopep_decode.sv @@
// Per-character decode: token and next parse state from one character and
// the current parse state. Purely combinational. Depends on sopep_pkg.
module sopep_decode (
   input  sopep_pkg::req_type        item,
   input  sopep_pkg::scan_state_type state,
   output sopep_pkg::rsp_type        token,
   output sopep_pkg::scan_state_type state_next
);
   import sopep_pkg::*;

   logic       line_end;
   logic       upper;
   logic       lower;
   logic       space;
   logic [7:0] upper_ofs;
   logic [7:0] lower_ofs;
   logic [4:0] var_idx;
   logic [4:0] bind_idx;
   logic [VAR_COUNT-1:0] var_bit;

   assign line_end  = item.end_of_text || (item.character == CH_NEWLINE);
   assign upper     = !item.end_of_text && (item.character >= CH_UPPER_A) &&
                      (item.character <= CH_UPPER_Z);
   assign lower     = !item.end_of_text && (item.character >= CH_LOWER_A) &&
                      (item.character <= CH_LOWER_Z);
   assign space     = !item.end_of_text && (item.character == CH_SPACE);
   assign upper_ofs = item.character - CH_UPPER_A;
   assign lower_ofs = item.character - CH_LOWER_A;
   assign var_idx   = upper_ofs[4:0];
   assign bind_idx  = lower_ofs[4:0];
   assign var_bit   = VAR_COUNT'(1) << var_idx;

   always_comb begin
      token      = '0;
      state_next = state;
      unique case (state.phase)
         PH_EQ: begin
            priority if (space) begin
            end else if (line_end) begin
               token.token_kind = TK_ERR;
               token.error_code = ER_EARLY;
            end else if (item.character == CH_EQUALS) begin
               state_next.phase = PH_VAR;
            end else begin
               token.token_kind = TK_ERR;
               token.error_code = ER_EQ;
            end
         end
         PH_VAR: begin
            priority if (space) begin
            end else if (line_end) begin
               token.token_kind = TK_ERR;
               token.error_code = ER_EARLY;
            end else if (upper) begin
               token.token_kind     = TK_VAR;
               token.variable_index = var_idx;
               state_next.mask      = state.mask | var_bit;
               state_next.phase     = PH_AFTER_VAR;
            end else begin
               token.token_kind = TK_ERR;
               token.error_code = ER_VAR;
            end
         end
         PH_AFTER_VAR, PH_AFTER_GAP: begin
            priority if (line_end) begin
               token.token_kind     = TK_END;
               token.binding_index  = state.binding;
               token.variables_used = state.mask;
               state_next.phase     = PH_BIND;
               state_next.mask      = '0;
            end else if (space) begin
               state_next.phase = PH_AFTER_GAP;
            end else if ((item.character == CH_QUOTE) &&
                         (state.phase == PH_AFTER_VAR)) begin
               token.token_kind = TK_INV;
               state_next.phase = PH_AFTER_GAP;
            end else if (upper) begin
               token.token_kind     = TK_VAR;
               token.variable_index = var_idx;
               state_next.mask      = state.mask | var_bit;
               state_next.phase     = PH_AFTER_VAR;
            end else if (item.character == CH_PLUS) begin
               token.token_kind = TK_TERM;
               state_next.phase = PH_VAR;
            end else begin
               token.token_kind = TK_ERR;
               token.error_code = ER_BAD;
            end
         end
         default: begin
            // binding phase; unused codes behave the same
            state_next.phase = PH_BIND;
            priority if (line_end || space) begin
            end else if (lower) begin
               state_next.binding = bind_idx;
               state_next.mask    = '0;
               state_next.phase   = PH_EQ;
            end else begin
               token.token_kind = TK_ERR;
               token.error_code = ER_BIND;
            end
         end
      endcase

      // any error drops the character and restarts at the binding letter
      if (token.token_kind == TK_ERR) begin
         state_next.phase = PH_BIND;
         state_next.mask  = '0;
      end
   end

endmodule

@@ hdl/sum_of_products_equation_parser.sv @@
// Top level of the sum-of-products equation parser: input register, decode,
// parse state and result register. Depends on sopep_pkg and sopep_decode.
//
// Usage:
//   Feed equation text such as "x = A B' + C D'" one character per transfer
//   on the req_ channel (req_payload.character, or req_payload.end_of_text
//   to mark end of input). Every accepted character yields exactly one
//   token on the rsp_ channel: none, variable, invert last, term break,
//   equation end (binding letter and 26-bit mask of variables used) or
//   error. Tokens leave in the order the characters arrived.
//   Path: an accepted character sits in the input register, then its token
//   is written to the result register, which drives rsp_valid.
//   Throughput: one character per cycle while rsp_stall is low, set by the
//   combinational decode between the two registers; the parse state updates
//   as each character moves from the input register to the result register.
//   Stall: while rsp_stall holds a waiting token, the result register holds
//   and the input register still takes one more character; req_stall rises
//   only when both registers are full and the result cannot drain.
//   Reset: clears both valid flags and the parse state (binding letter
//   expected, binding letter and mask zero).
module sum_of_products_equation_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sopep_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sopep_pkg::rsp_type rsp_payload
);
   import sopep_pkg::*;

   logic           in_valid_ff;
   logic           in_valid_in;
   req_type        in_data_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   rsp_type        out_data_ff;
   scan_state_type state_ff;
   scan_state_type state_next;
   rsp_type        token;
   logic           out_open;
   logic           advance;
   logic           req_take;

   sopep_decode u_decode (
      .item       (in_data_ff),
      .state      (state_ff),
      .token      (token),
      .state_next (state_next)
   );

   // result register can take a token when empty or draining this cycle
   assign out_open  = !out_valid_ff || !rsp_stall;
   // move the held character through decode into the result register
   assign advance   = in_valid_ff && out_open;
   // input register frees up when empty or when its character advances
   assign req_stall = in_valid_ff && !out_open;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_BIND, binding: '0, mask: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   // payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= token;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

@@ tb/sum_of_products_equation_parser_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sum_of_products_equation_parser: a directed table,
// then random equation text, each token checked against a typed token or a parse model here.
// Depends on sopep_pkg and the parser RTL.
module sum_of_products_equation_parser_test;
   import sopep_pkg::*;

   localparam int RANDOM_ITEMS   = 1450;
   localparam int MAX_REPORTS    = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam bit TYPED          = 1'b1;
   localparam bit PREDICTED      = 1'b0;

   // One character of text, with the token typed into the table where it is
   // plain to read; otherwise the parse model decides the token.
   typedef struct {
      req_type item;
      bit      typed_in;
      rsp_type token;
   } text_entry_type;

   // Ways to break a well-formed line.
   typedef enum int {
      BREAK_REPLACE,
      BREAK_DROP,
      BREAK_INSERT,
      BREAK_QUOTE,
      BREAK_NEWLINE
   } break_kind_type;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   text_entry_type  text_stream[$];
   text_entry_type  held_entry;
   rsp_type         pending_tokens[$];
   req_type         line_buf[$];
   scan_state_type  model_state;
   int              fault_count = 0;
   int              idle_cycles = 0;
   int              stall_left  = 0;
   bit              steady      = 1'b0;

   sum_of_products_equation_parser u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Parse model
   // ------------------------------------------------------------------

   function automatic rsp_type make_token(logic [2:0] kind, logic [4:0] var_idx,
                                          logic [4:0] bind_idx,
                                          logic [VAR_COUNT-1:0] used, logic [2:0] code);
      rsp_type t;
      t.token_kind     = kind;
      t.variable_index = var_idx;
      t.binding_index  = bind_idx;
      t.variables_used = used;
      t.error_code     = code;
      return t;
   endfunction

   // Drop the character and restart at the binding letter with the mask cleared.
   function automatic rsp_type error_token(logic [2:0] code);
      model_state.phase = PH_BIND;
      model_state.mask  = '0;
      return make_token(TK_ERR, '0, '0, '0, code);
   endfunction

   function automatic rsp_type variable_token(logic [7:0] ch);
      logic [4:0] idx;
      idx                   = 5'(ch - CH_UPPER_A);
      model_state.mask[idx] = 1'b1;
      model_state.phase     = PH_AFTER_VAR;
      return make_token(TK_VAR, idx, '0, '0, '0);
   endfunction

   // Advance the parse state by one character and return its token.
   function automatic rsp_type tokenize_char(req_type item);
      logic [7:0] ch;
      logic       line_end, upper, lower, blank;
      logic [2:0] ph;
      rsp_type    tok;
      ch       = item.character;
      line_end = item.end_of_text || ch == CH_NEWLINE;
      upper    = !item.end_of_text && ch >= CH_UPPER_A && ch <= CH_UPPER_Z;
      lower    = !item.end_of_text && ch >= CH_LOWER_A && ch <= CH_LOWER_Z;
      blank    = !item.end_of_text && ch == CH_SPACE;
      // phases past the last one fall back to the binding phase
      ph       = (model_state.phase > PH_AFTER_GAP) ? PH_BIND : model_state.phase;
      tok      = make_token(TK_NONE, '0, '0, '0, '0);
      case (ph)
         PH_BIND: begin
            model_state.phase = PH_BIND;
            if (lower) begin
               model_state.binding = 5'(ch - CH_LOWER_A);
               model_state.mask    = '0;
               model_state.phase   = PH_EQ;
            end else if (!line_end && !blank) begin
               tok = error_token(ER_BIND);
            end
         end
         PH_EQ: begin
            if (line_end) tok = error_token(ER_EARLY);
            else if (ch == CH_EQUALS) model_state.phase = PH_VAR;
            else if (!blank) tok = error_token(ER_EQ);
         end
         PH_VAR: begin
            if (line_end) tok = error_token(ER_EARLY);
            else if (upper) tok = variable_token(ch);
            else if (!blank) tok = error_token(ER_VAR);
         end
         default: begin
            if (line_end) begin
               tok = make_token(TK_END, '0, model_state.binding, model_state.mask, '0);
               model_state.phase = PH_BIND;
               model_state.mask  = '0;
            end else if (blank) begin
               model_state.phase = PH_AFTER_GAP;
            end else if (ch == CH_QUOTE && ph == PH_AFTER_VAR) begin
               tok = make_token(TK_INV, '0, '0, '0, '0);
               model_state.phase = PH_AFTER_GAP;
            end else if (upper) begin
               tok = variable_token(ch);
            end else if (ch == CH_PLUS) begin
               tok = make_token(TK_TERM, '0, '0, '0, '0);
               model_state.phase = PH_VAR;
            end else begin
               tok = error_token(ER_BAD);
            end
         end
      endcase
      return tok;
   endfunction

   // Compare a token against the oldest expectation, field by field.
   function automatic void check_token(rsp_type got);
      rsp_type want;
      if (pending_tokens.size() == 0) begin
         fault_count++;
         if (fault_count <= MAX_REPORTS)
            $display("%0t: token with none expected: ", $time,
                     "kind %0d var %0d bind %0d used %h code %0d",
                     got.token_kind, got.variable_index, got.binding_index,
                     got.variables_used, got.error_code);
         return;
      end
      want = pending_tokens.pop_front();
      if (got.token_kind !== want.token_kind || got.variable_index !== want.variable_index ||
          got.binding_index !== want.binding_index ||
          got.variables_used !== want.variables_used || got.error_code !== want.error_code) begin
         fault_count++;
         if (fault_count <= MAX_REPORTS)
            $display("%0t: token mismatch: ", $time,
                     "expected kind %0d var %0d bind %0d used %h code %0d, ",
                     want.token_kind, want.variable_index, want.binding_index,
                     want.variables_used, want.error_code,
                     "got kind %0d var %0d bind %0d used %h code %0d",
                     got.token_kind, got.variable_index, got.binding_index,
                     got.variables_used, got.error_code);
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   function automatic req_type text_char(logic [7:0] ch, logic eot = 1'b0);
      req_type r;
      r.character   = ch;
      r.end_of_text = eot;
      return r;
   endfunction

   function automatic text_entry_type row(logic [7:0] ch, logic eot, bit typed_in,
                                          logic [2:0] kind, logic [2:0] code,
                                          logic [4:0] var_idx);
      text_entry_type e;
      e.item     = text_char(ch, eot);
      e.typed_in = typed_in;
      e.token    = make_token(kind, var_idx, '0, '0, code);
      return e;
   endfunction

   function automatic text_entry_type model_entry(req_type item);
      text_entry_type e;
      e.item     = item;
      e.typed_in = PREDICTED;
      e.token    = '0;
      return e;
   endfunction

   // Append one character to the line under construction.
   function automatic void line_add(req_type r);
      line_buf.insert(line_buf.size(), r);
   endfunction

   // Append one entry to the text stream.
   function automatic void text_add(text_entry_type e);
      text_stream.insert(text_stream.size(), e);
   endfunction

   function automatic void add_blanks();
      int n;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n) line_add(text_char(CH_SPACE));
   endfunction

   // Build one equation line with random content, then break about one in five.
   function automatic void add_equation();
      int             terms, factors, p;
      break_kind_type pick;
      line_buf.delete();
      add_blanks();
      line_add(text_char(8'(CH_LOWER_A + $urandom_range(0, 25))));
      add_blanks();
      line_add(text_char(CH_EQUALS));
      add_blanks();
      terms = $urandom_range(1, 4);
      for (int t = 0; t < terms; t++) begin
         if (t > 0) begin
            add_blanks();
            line_add(text_char(CH_PLUS));
            add_blanks();
         end
         factors = $urandom_range(1, 4);
         for (int f = 0; f < factors; f++) begin
            if (f > 0 && $urandom_range(0, 1) == 1) line_add(text_char(CH_SPACE));
            line_add(text_char(8'(CH_UPPER_A + $urandom_range(0, 25))));
            if ($urandom_range(0, 2) == 0) line_add(text_char(CH_QUOTE));
         end
      end
      add_blanks();
      // close a few lines with end of text, carrying a random character
      if ($urandom_range(0, 7) == 0)
         line_add(text_char(8'($urandom_range(0, 255)), 1'b1));
      else
         line_add(text_char(CH_NEWLINE));
      if ($urandom_range(0, 4) == 0) begin
         p    = $urandom_range(0, line_buf.size() - 1);
         pick = break_kind_type'($urandom_range(0, 4));
         case (pick)
            BREAK_REPLACE: line_buf[p].character = 8'($urandom_range(0, 255));
            BREAK_DROP:    line_buf.delete(p);
            BREAK_INSERT:  line_buf.insert(p, text_char(8'($urandom_range(0, 255))));
            BREAK_QUOTE:   line_buf.insert(p, text_char(CH_QUOTE));
            default:       line_buf.insert(p, text_char(CH_NEWLINE));
         endcase
      end
      foreach (line_buf[i]) text_add(model_entry(line_buf[i]));
   endfunction

   function automatic void build_text();
      int goal;
      // Directed table: character, end of text, how the token is known,
      // then the typed token kind, error code and variable index.
      // blanks and end of text while a binding letter is expected
      text_add(row(CH_SPACE,   1'b0, TYPED,     TK_NONE, '0,       '0));
      text_add(row(8'hFF,      1'b1, TYPED,     TK_NONE, '0,       '0));
      // lowest and highest byte in place of a binding letter
      text_add(row(8'h00,      1'b0, TYPED,     TK_ERR,  ER_BIND,  '0));
      text_add(row(8'hFF,      1'b0, TYPED,     TK_ERR,  ER_BIND,  '0));
      // newline before the equals sign
      text_add(row(CH_LOWER_A, 1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_NEWLINE, 1'b0, TYPED,     TK_ERR,  ER_EARLY, '0));
      // wrong character where the equals sign belongs
      text_add(row(CH_LOWER_Z, 1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row("x",        1'b0, TYPED,     TK_ERR,  ER_EQ,    '0));
      // lowercase letter where a variable belongs
      text_add(row(CH_LOWER_Z, 1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_EQUALS,  1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_LOWER_A, 1'b0, TYPED,     TK_ERR,  ER_VAR,   '0));
      // first variable, invert, term break, then newline right after '+'
      text_add(row(CH_LOWER_Z, 1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_EQUALS,  1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_UPPER_A, 1'b0, TYPED,     TK_VAR,  '0,       5'd0));
      text_add(row(CH_QUOTE,   1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_PLUS,    1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_NEWLINE, 1'b0, TYPED,     TK_ERR,  ER_EARLY, '0));
      // last variable, then a quote behind a space
      text_add(row("m",        1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_EQUALS,  1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_UPPER_Z, 1'b0, TYPED,     TK_VAR,  '0,       5'd25));
      text_add(row(CH_SPACE,   1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_QUOTE,   1'b0, TYPED,     TK_ERR,  ER_BAD,   '0));
      // a whole equation closed by a newline
      text_add(row("b",        1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_EQUALS,  1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_UPPER_Z, 1'b0, PREDICTED, TK_NONE, '0,       '0));
      text_add(row(CH_NEWLINE, 1'b0, PREDICTED, TK_NONE, '0,       '0));

      // Random text: mostly equations, now and then a burst of raw bytes.
      goal = text_stream.size() + RANDOM_ITEMS;
      while (text_stream.size() < goal) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5))
               text_add(model_entry(text_char(8'($urandom_range(0, 255)),
                                              $urandom_range(0, 7) == 0)));
         end else begin
            add_equation();
         end
      end
   endfunction

   // Idle length in cycles: mostly none or short, a few long; none while steady.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------
   // Sender: hold reset, then present each character until its transfer.
   // ------------------------------------------------------------------
   initial begin
      int gap;
      build_text();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < text_stream.size(); i++) begin
         // run every fourth stretch of 250 characters with no idling at all
         steady <= ((i / 250) % 4 == 3);
         gap = idle_length();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_payload <= text_stream[i].item;
         held_entry  <= text_stream[i];
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      req_valid <= 1'b0;

      // drain: wait for every token, then allow stray ones to show up
      @(posedge clock);
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_tokens.size() == 0)
         $display("[sum_of_products_equation_parser] OK");
      else
         $display("[sum_of_products_equation_parser] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Receiver: stall in random runs, independent of rsp_valid.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      int hold;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         hold        = idle_length();
         rsp_stall  <= (hold != 0);
         stall_left <= (hold > 0) ? hold - 1 : 0;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each result transfer, predict each request transfer,
   // and stop the run if nothing moves for too long.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type predicted;
      if (reset) begin
         model_state.phase   = PH_BIND;
         model_state.binding = '0;
         model_state.mask    = '0;
         pending_tokens.delete();
         idle_cycles <= 0;
      end else begin
         // check before predicting so a surplus token never meets a fresh expectation
         if (rsp_valid && !rsp_stall) check_token(rsp_payload);
         if (req_valid && !req_stall) begin
            // always advance the model; a typed token overrides its prediction
            predicted = tokenize_char(req_payload);
            pending_tokens.insert(pending_tokens.size(),
                                  held_entry.typed_in ? held_entry.token : predicted);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[sum_of_products_equation_parser] ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

endmodule
